/* sv/binary_gcd_core_macros.svh */
// Assertion macros for the binary GCD core.
// Used by binary_gcd_core.sv; expects i_clk and i_rst_n in scope.
`ifndef BINARY_GCD_CORE_MACROS_SVH
`define BINARY_GCD_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BGCD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("binary_gcd_core: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BGCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("binary_gcd_core: next-cycle check failed");

`endif

/* sv/bgcd_pkg.sv */
// Shared types and constants for the binary GCD core.
// No dependencies; imported by the controller, datapath and top level.
package bgcd_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STRIP,
        S_ODD_U,
        S_REDUCE,
        S_FINISH
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic strip;
        logic halve_u;
        logic halve_v;
        logic reduce;
        logic finish;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic any_zero;
        logic u_even;
        logic v_even;
        logic u_eq_v;
    } t_status;

endpackage

/* sv/bgcd_ctrl.sv */
// Controller state machine for the binary GCD core.
// Depends on bgcd_pkg (state, command and status types).
module bgcd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  bgcd_pkg::t_status i_status,
    output bgcd_pkg::t_cmd    o_cmd,
    output logic              o_busy
);
    import bgcd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_STRIP;
                end
            end
            S_STRIP: begin
                if (i_status.any_zero) begin
                    n_state = S_FINISH;
                end else if (!(i_status.u_even && i_status.v_even)) begin
                    n_state = S_ODD_U;
                end
            end
            S_ODD_U: begin
                if (!i_status.u_even) begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                // v odd and equal to u: the subtract leaves zero
                if (!i_status.v_even && i_status.u_eq_v) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_STRIP: begin
                o_cmd.strip = !i_status.any_zero && i_status.u_even && i_status.v_even;
            end
            S_ODD_U: begin
                o_cmd.halve_u = i_status.u_even;
            end
            S_REDUCE: begin
                o_cmd.halve_v = i_status.v_even;
                o_cmd.reduce  = !i_status.v_even;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

endmodule

/* sv/bgcd_dp.sv */
// Datapath for the binary GCD core: operand registers, shared-twos counter,
// subtract/compare logic and the result register. Depends on bgcd_pkg.
module bgcd_dp #(
    parameter int DATA_WIDTH = bgcd_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bgcd_pkg::t_cmd        i_cmd,
    input  logic [DATA_WIDTH-1:0] i_operand_a,
    input  logic [DATA_WIDTH-1:0] i_operand_b,
    output bgcd_pkg::t_status     o_status,
    output logic [DATA_WIDTH-1:0] o_divisor,
    output logic                  o_valid
);
    import bgcd_pkg::*;

    localparam int CW = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] r_u;
    logic [DATA_WIDTH-1:0] r_v;
    logic [CW-1:0]         r_twos;
    logic [DATA_WIDTH-1:0] r_divisor;
    logic                  r_valid;

    logic [DATA_WIDTH-1:0] mag_a;
    logic [DATA_WIDTH-1:0] mag_b;
    logic [DATA_WIDTH:0]   diff;
    logic                  u_gt_v;

    // Two's complement magnitude; the most negative value maps to 2^(W-1)
    assign mag_a = i_operand_a[DATA_WIDTH-1] ? (~i_operand_a + DATA_WIDTH'(1)) : i_operand_a;
    assign mag_b = i_operand_b[DATA_WIDTH-1] ? (~i_operand_b + DATA_WIDTH'(1)) : i_operand_b;

    assign diff   = {1'b0, r_v} - {1'b0, r_u};
    assign u_gt_v = diff[DATA_WIDTH];

    assign o_status.any_zero = (r_u == '0) || (r_v == '0);
    assign o_status.u_even   = !r_u[0];
    assign o_status.v_even   = !r_v[0];
    assign o_status.u_eq_v   = (diff == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_u    <= mag_a;
            r_v    <= mag_b;
            r_twos <= '0;
        end else if (i_cmd.strip) begin
            r_u    <= r_u >> 1;
            r_v    <= r_v >> 1;
            r_twos <= r_twos + CW'(1);
        end else if (i_cmd.halve_u) begin
            r_u <= r_u >> 1;
        end else if (i_cmd.halve_v) begin
            r_v <= r_v >> 1;
        end else if (i_cmd.reduce) begin
            // keep the smaller in u, the absolute difference in v
            if (u_gt_v) begin
                r_u <= r_v;
                r_v <= r_u - r_v;
            end else begin
                r_v <= diff[DATA_WIDTH-1:0];
            end
        end
    end

    // At finish one of u, v is zero, so u | v is the odd part (or the other operand)
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_divisor <= (r_u | r_v) << r_twos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    assign o_divisor = r_divisor;
    assign o_valid   = r_valid;

endmodule

/* sv/binary_gcd_core.sv */
// Binary GCD core: gcd of two signed operand magnitudes, Stein's method.
// The loop does one halving or one subtract per cycle; one request at a time.
// busy drops on the cycle of o_valid, so the next request can start then.
// Reset (i_rst_n low, synchronous) returns the controller to idle and clears o_valid.
// Results are strobed for one cycle; the receiver cannot stall.
`include "binary_gcd_core_macros.svh"

module binary_gcd_core #(
    parameter int DATA_WIDTH = bgcd_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] i_operand_a,
    input  logic signed [DATA_WIDTH-1:0] i_operand_b,
    output logic        [DATA_WIDTH-1:0] o_divisor,
    output logic                         o_valid
);
    import bgcd_pkg::*;

    t_cmd    cmd;
    t_status status;

    bgcd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    bgcd_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_operand_a ($unsigned(i_operand_a)),
        .i_operand_b ($unsigned(i_operand_b)),
        .o_status    (status),
        .o_divisor   (o_divisor),
        .o_valid     (o_valid)
    );

    `BGCD_ASSERT_NEXT(a_req_takes_busy, start && !busy, busy)
    `BGCD_ASSERT_IMPL(a_done_on_busy_fall, $fell(busy), o_valid)
    `BGCD_ASSERT_IMPL(a_valid_when_idle, o_valid, !busy)
    `BGCD_ASSERT_NEXT(a_single_result, o_valid, !o_valid)

endmodule

/* tb/sv/testbench.sv */
// Self-checking bench for binary_gcd_core: directed corner pairs, then random operand pairs.
// Needs bgcd_pkg and binary_gcd_core; a scoreboard class predicts each gcd and checks it.
module testbench;

    localparam int W = bgcd_pkg::DATA_WIDTH_DEF;
    localparam int RANDOM_REQUESTS = 1050;
    localparam int SETTLE_CYCLES = 4 * W + 16;
    localparam int CYCLE_LIMIT = 1000000;

    // Keeps the gcd values still owed by the core, oldest first.
    class divisor_book;
        logic [W-1:0] owed_divisors[$];
        int mismatches;
        int results_seen;
        int zero_operand_pairs;

        function new();
            mismatches = 0;
            results_seen = 0;
            zero_operand_pairs = 0;
        endfunction

        task report(input string what);
            $display("MISMATCH @%0t: %s", $time, what);
            mismatches++;
        endtask

        static function logic [W-1:0] magnitude(input logic [W-1:0] raw);
            return raw[W-1] ? (~raw + 1'b1) : raw;
        endfunction

        // Stein's method on the operand magnitudes.
        static function logic [W-1:0] gcd_of(input logic [W-1:0] a, input logic [W-1:0] b);
            logic [W-1:0] u;
            logic [W-1:0] v;
            logic [W-1:0] t;
            int twos;
            u = magnitude(a);
            v = magnitude(b);
            twos = 0;
            if (u == '0) return v;
            if (v == '0) return u;
            while (u[0] == 1'b0 && v[0] == 1'b0) begin
                u = u >> 1;
                v = v >> 1;
                twos++;
            end
            while (u[0] == 1'b0) u = u >> 1;
            do begin
                while (v[0] == 1'b0) v = v >> 1;
                if (u > v) begin
                    t = u;
                    u = v;
                    v = t;
                end
                v = v - u;
            end while (v != '0);
            return u << twos;
        endfunction

        function void note_request(input logic [W-1:0] a, input logic [W-1:0] b);
            if (a == '0 || b == '0) zero_operand_pairs++;
            owed_divisors.push_back(gcd_of(a, b));
        endfunction

        task check_result(input logic [W-1:0] divisor);
            logic [W-1:0] want;
            results_seen++;
            if (owed_divisors.size() == 0) begin
                report($sformatf("divisor %0d with no request outstanding", divisor));
            end else begin
                want = owed_divisors.pop_front();
                if (divisor !== want)
                    report($sformatf("divisor got %0d, want %0d", divisor, want));
            end
        endtask

        function int pending();
            return owed_divisors.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic signed [W-1:0] i_operand_a;
    logic signed [W-1:0] i_operand_b;
    logic        [W-1:0] o_divisor;
    logic                o_valid;

    divisor_book book;
    int unsigned cycle_count;
    int request_index;

    binary_gcd_core #(
        .DATA_WIDTH(W)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_operand_a(i_operand_a),
        .i_operand_b(i_operand_b),
        .o_divisor  (o_divisor),
        .o_valid    (o_valid)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Results cannot be held off: take every strobe.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) book.check_result(o_divisor);
    end

    // Random idle gaps between requests, with runs of back-to-back requests.
    function automatic int draw_gap();
        if ((request_index % 97) < 20) return 0;
        return $urandom_range(0, 13);
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_request(input logic [W-1:0] a, input logic [W-1:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (busy !== 1'b0);
        book.note_request(a, b);
        request_index++;
    endtask

    // Hold off new requests until every owed result is back.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (book.pending() != 0);
    endtask

    task automatic make_pair(output logic [W-1:0] a, output logic [W-1:0] b);
        logic [W-1:0] common;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 2) begin
            a = $urandom();
            b = $urandom();
        end else if (kind <= 7) begin
            // Shared odd factor and shared powers of two.
            common = ($urandom_range(1, 65535) | 1) << $urandom_range(0, 12);
            a = common * $urandom_range(1, 1 << $urandom_range(1, 16));
            b = common * $urandom_range(1, 1 << $urandom_range(1, 16));
            if ($urandom_range(0, 1)) a = -a;
            if ($urandom_range(0, 1)) b = -b;
        end else if (kind == 8) begin
            a = $urandom();
            b = '0;
            if ($urandom_range(0, 1)) begin
                b = a;
                a = '0;
            end
        end else begin
            a = {1'b1, {(W - 1){1'b0}}} >> $urandom_range(0, W - 1);
            b = $urandom_range(0, 1) ? {1'b0, {(W - 1){1'b1}}} : $urandom();
            if ($urandom_range(0, 1)) a = -a;
            if ($urandom_range(0, 1)) b = b << $urandom_range(0, W - 1);
        end
    endtask

    initial begin
        logic [W-1:0] corner_a[$];
        logic [W-1:0] corner_b[$];
        logic [W-1:0] a;
        logic [W-1:0] b;

        book = new();
        request_index = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_operand_a <= '0;
        i_operand_b <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zeros, most negative value, largest positive, signs, shared twos.
        corner_a = '{32'd0, 32'd0, 32'd7, 32'd0, 32'h8000_0000, 32'h8000_0000,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'd1, 32'd12,
                     -32'sd12, 32'd48, 32'h4000_0000, 32'h8000_0000, 32'h7fff_ffff,
                     32'h3000_0000, 32'd0, -32'sd5, 32'd100, 32'd1, 32'd1836311903,
                     32'hffff_fffe, 32'h5555_5555};
        corner_b = '{32'd0, 32'd5, 32'd0, 32'h8000_0000, 32'd0, 32'h8000_0000,
                     32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff,
                     32'd18, 32'd18, -32'sd180, 32'h0010_0000, 32'd6, 32'h7fff_fffe,
                     32'h0090_0000, 32'hffff_ffff, 32'd0, 32'd100, 32'd1,
                     32'd1134903170, 32'h8000_0000, 32'haaaa_aaaa};
        foreach (corner_a[i]) send_request(corner_a[i], corner_b[i]);
        drain();

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            make_pair(a, b);
            send_request(a, b);
            if (n % 150 == 149) drain();
        end
        start <= 1'b0;

        while (book.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        while (book.pending() != 0) begin
            book.report($sformatf("divisor %0d never arrived", book.owed_divisors.pop_front()));
        end

        $display("%0d gcd requests (%0d with a zero operand), %0d results checked",
                 request_index, book.zero_operand_pairs, book.results_seen);
        $display("%0d mismatches", book.mismatches);
        if (book.mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
